// ----- rtl/vte_pkg.sv -----
// Shared types and constants for the vector-to-distance pipeline.
// No dependencies; used by every module under rtl/.
package vte_pkg;

    localparam int COMP_W      = 16;  // width of one offset component on the bus
    localparam int SQ_W        = 32;  // squared norm width
    localparam int ROOT_W      = 16;  // integer square root width
    localparam int REM_W       = 17;  // remainder n - r*r is at most 2r
    localparam int SQRT_STAGES = 16;  // one root bit per stage
    localparam int DIST_W      = 32;

    // Configuration register indexes
    localparam logic CFG_SQUARED_MODE = 1'b0;
    localparam logic CFG_OUT_FORMAT   = 1'b1;

    typedef enum logic [1:0] {
        FMT_SAT8  = 2'd0,
        FMT_SAT16 = 2'd1,
        FMT_RAW   = 2'd2
    } fmt_t;

    // Word handed from the root pipeline to the output stage
    typedef struct packed {
        logic [SQ_W-1:0]   norm_sq;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_word_t;

endpackage

// ----- rtl/vector_to_euclidean_distance.sv -----
// Vector-to-distance top level: config registers and the three pipeline parts.
// Depends on vte_pkg, vte_square, vte_sqrt and vte_out.
//
// Takes one offset word (x, y, z) per clock unless stalled and returns one
// distance word per word accepted, in order. Three register stages compute
// magnitudes, squares and sum, sixteen the square root (one root bit per
// stage) and one rounding and saturation. Every stage has its own valid bit
// and stalls only when the stage after it is full, so bubbles close up and
// input flows on while a word waits at the output, until every stage is full.
// Write the configuration registers only while no word is in flight.
module vector_to_euclidean_distance #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] off_x, [31:16] off_y, [47:32] off_z
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] distance
);

    logic                     squared_mode_reg;
    vte_pkg::fmt_t            out_format_reg;
    logic                     sq_valid, sq_ready;
    logic [vte_pkg::SQ_W-1:0] sq_norm;
    logic                     rt_valid, rt_ready;
    vte_pkg::root_word_t      rt_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            squared_mode_reg <= 1'b0;
            out_format_reg   <= vte_pkg::FMT_SAT8;
        end else if (cfg_we) begin
            case (cfg_addr)
                vte_pkg::CFG_SQUARED_MODE: squared_mode_reg <= cfg_wdata[0];
                vte_pkg::CFG_OUT_FORMAT:   out_format_reg   <= vte_pkg::fmt_t'(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    vte_square #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_square (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .out_valid  (sq_valid),
        .out_ready  (sq_ready),
        .out_norm_sq(sq_norm)
    );

    vte_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_norm_sq(sq_norm),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_word  (rt_word)
    );

    vte_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .squared_mode(squared_mode_reg),
        .out_format  (out_format_reg),
        .in_valid    (rt_valid),
        .in_ready    (rt_ready),
        .in_word     (rt_word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_distance(m_tdata)
    );

endmodule

// ----- rtl/vte_square.sv -----
// Squared norm pipeline: component magnitudes, squares, and their sum.
// Three register stages with per-stage valid; depends on vte_pkg.
module vte_square #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3*vte_pkg::COMP_W-1:0] in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [vte_pkg::SQ_W-1:0]    out_norm_sq
);

    logic [vte_pkg::COMP_W-1:0] mag_next [3];
    logic [vte_pkg::COMP_W-1:0] mag_reg  [3];
    logic [vte_pkg::SQ_W-1:0]   sq_reg   [3];
    logic [vte_pkg::SQ_W-1:0]   sum_next;
    logic [vte_pkg::SQ_W-1:0]   sum_reg;
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       rdy1, rdy2, rdy3;

    // Sign-extend from COMPONENT_BITS-1 and take the magnitude; the most
    // negative value maps onto itself, read as unsigned.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [COMPONENT_BITS-1:0] low;
            low = in_data[i*vte_pkg::COMP_W +: COMPONENT_BITS];
            if (low[COMPONENT_BITS-1]) begin
                mag_next[i] = vte_pkg::COMP_W'(COMPONENT_BITS'(~low + 1'b1));
            end else begin
                mag_next[i] = vte_pkg::COMP_W'(low);
            end
        end
    end

    assign sum_next = vte_pkg::SQ_W'(sq_reg[0] + sq_reg[1] + sq_reg[2]);

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            mag_reg <= mag_next;
        end
        if (rdy2 && v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
        end
        if (rdy3 && v2_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid   = v3_reg;
    assign out_norm_sq = sum_reg;

endmodule

// ----- rtl/vte_sqrt.sv -----
// Pipelined integer square root: one result bit per stage, remainder kept.
// Depends on vte_pkg for widths and the root_word_t output word.
module vte_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [vte_pkg::SQ_W-1:0] in_norm_sq,
    output logic                     out_valid,
    input  logic                     out_ready,
    output vte_pkg::root_word_t      out_word
);

    localparam int N = vte_pkg::SQRT_STAGES;

    logic [vte_pkg::SQ_W-1:0] n_reg   [N];
    logic [vte_pkg::SQ_W-1:0] rem_reg [N];
    logic [vte_pkg::SQ_W-1:0] res_reg [N];
    logic [N-1:0]             valid_reg;
    logic [N:0]               stage_ready;

    assign stage_ready[N] = out_ready;
    assign in_ready       = stage_ready[0];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam logic [vte_pkg::SQ_W-1:0] BIT =
            vte_pkg::SQ_W'(1) << (2 * (N - 1 - s));

        logic                     v_in;
        logic [vte_pkg::SQ_W-1:0] n_in, rem_in, res_in;
        logic [vte_pkg::SQ_W:0]   trial;
        logic [vte_pkg::SQ_W-1:0] rem_next, res_next;

        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign n_in   = in_norm_sq;
            assign rem_in = in_norm_sq;
            assign res_in = '0;
        end else begin : g_rest
            assign v_in   = valid_reg[s-1];
            assign n_in   = n_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        assign trial = {1'b0, res_in} + {1'b0, BIT};

        always_comb begin
            if ({1'b0, rem_in} >= trial) begin
                rem_next = rem_in - trial[vte_pkg::SQ_W-1:0];
                res_next = (res_in >> 1) + BIT;
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[s] && v_in) begin
                n_reg[s]   <= n_in;
                rem_reg[s] <= rem_next;
                res_reg[s] <= res_next;
            end
        end
    end

    assign out_valid        = valid_reg[N-1];
    assign out_word.norm_sq = n_reg[N-1];
    assign out_word.rem     = rem_reg[N-1][vte_pkg::REM_W-1:0];
    assign out_word.root    = res_reg[N-1][vte_pkg::ROOT_W-1:0];

endmodule

// ----- rtl/vte_out.sv -----
// Output stage: round the root to nearest, pick squared or root, saturate.
// Holds the result word until taken; depends on vte_pkg.
module vte_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       squared_mode,
    input  vte_pkg::fmt_t              out_format,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  vte_pkg::root_word_t        in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [vte_pkg::DIST_W-1:0] out_distance
);

    logic [vte_pkg::REM_W-1:0]  rounded;
    logic [vte_pkg::DIST_W-1:0] value;
    logic [vte_pkg::DIST_W-1:0] dist_next;
    logic [vte_pkg::DIST_W-1:0] dist_reg;
    logic                       valid_reg;

    // Round up when the remainder exceeds the root
    always_comb begin
        if (in_word.rem > vte_pkg::REM_W'(in_word.root)) begin
            rounded = vte_pkg::REM_W'(in_word.root) + 1'b1;
        end else begin
            rounded = vte_pkg::REM_W'(in_word.root);
        end
        value = squared_mode ? in_word.norm_sq : vte_pkg::DIST_W'(rounded);
    end

    always_comb begin
        case (out_format)
            vte_pkg::FMT_SAT8: begin
                dist_next = (value > 32'd255) ? 32'd255 : value;
            end
            vte_pkg::FMT_SAT16: begin
                dist_next = (value > 32'd65535) ? 32'd65535 : value;
            end
            default: begin
                dist_next = value;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dist_reg <= dist_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_distance = dist_reg;

endmodule

// ----- tb/sv/vte_distance_monitor.sv -----
// Watches the config port and both streams of vector_to_euclidean_distance,
// predicts each distance word and compares it with what comes out.
// Depends on vte_pkg.
module vte_distance_monitor
    import vte_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] off_x, [31:16] off_y, [47:32] off_z
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] distance
    output int          fail_count,
    output int          pending
);

    localparam longint unsigned SAT8_MAX  = 255;
    localparam longint unsigned SAT16_MAX = 65535;

    logic                squared_reg;
    logic [1:0]          format_reg;
    logic [DIST_W-1:0]   distance_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [DIST_W-1:0] predict_distance(
        input logic [47:0] word,
        input logic        squared,
        input logic [1:0]  format
    );
        longint unsigned fld, mag, norm, root, trial, dval;
        norm = 0;
        for (int k = 0; k < 3; k++) begin
            // only the low COMPONENT_BITS bits count, sign-extended
            fld = longint'(word[k*COMP_W +: COMP_W]) & ((64'd1 << COMPONENT_BITS) - 1);
            if (fld[COMPONENT_BITS-1])
                mag = (64'd1 << COMPONENT_BITS) - fld;
            else
                mag = fld;
            norm += mag * mag;
        end
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= norm)
                root = trial;
        end
        if (squared)
            dval = norm;
        else
            dval = (norm - root * root > root) ? root + 1 : root;
        case (format)
            FMT_SAT8:  if (dval > SAT8_MAX)  dval = SAT8_MAX;
            FMT_SAT16: if (dval > SAT16_MAX) dval = SAT16_MAX;
            default:   ;  // raw, and code three behaves as raw
        endcase
        return dval[DIST_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: distance mismatch, %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [DIST_W-1:0] want;
        int delta;
        delta = 0;
        if (!aresetn) begin
            squared_reg <= 1'b0;
            format_reg  <= FMT_SAT8;
            distance_q.delete();
            pending     <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_SQUARED_MODE)
                    squared_reg <= cfg_wdata[0];
                else
                    format_reg <= cfg_wdata;
            end
            // retire before predicting so a stray word never matches a fresh entry
            if (m_tvalid && m_tready) begin
                if (distance_q.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, '0);
                end else begin
                    want = distance_q.pop_front();
                    delta--;
                    if (m_tdata !== want)
                        report_mismatch("distance", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready) begin
                distance_q.push_back(predict_distance(s_tdata, squared_reg, format_reg));
                delta++;
            end
            pending <= pending + delta;
        end
    end

endmodule

// ----- tb/sv/vector_to_euclidean_distance_tb.sv -----
// Stimulus and verdict for vector_to_euclidean_distance: resets, walks through
// config settings, feeds offset words with random gaps and stalls.
// Depends on vte_pkg, the block and vte_distance_monitor.
module vector_to_euclidean_distance_tb;
    import vte_pkg::*;

    localparam int          COMPONENT_BITS = 16;
    localparam int unsigned CYCLE_LIMIT    = 500000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          TAIL_CYCLES    = 30;
    localparam int          PHASES         = 8;
    localparam int          WORDS_PER_PHASE = 88;
    localparam int          HOLD_PHASE     = 3;
    localparam logic [1:0]  FMT_CODE3      = 2'd3;  // undefined code, decodes as raw

    localparam bit         PHASE_SQUARED[PHASES] = '{0, 0, 0, 1, 1, 1, 1, 0};
    localparam logic [1:0] PHASE_FORMAT[PHASES]  = '{FMT_SAT16, FMT_RAW, FMT_CODE3, FMT_SAT8,
                                                     FMT_SAT16, FMT_RAW, FMT_CODE3, FMT_SAT8};

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    bit          hold_req = 1'b0;
    bit          tx_idles = 1'b0;
    bit          rx_idles = 1'b0;
    logic [47:0] corner_words[$];

    vector_to_euclidean_distance #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vte_distance_monitor #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) mon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [47:0] pack_word(input int x, input int y, input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'hffff;
                    3:       return 16'h0000;
                    default: return 16'h0001;
                endcase
            end
            1, 2, 3: return COMP_W'($urandom_range(600) - 300);  // around the 8-bit root edge
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_word();
        if ($urandom_range(31) == 0)
            return corner_words[$urandom_range(corner_words.size() - 1)];
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    task automatic send_word(input logic [47:0] word);
        int gap;
        gap = idle_len(tx_idles);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, wait for every predicted word, then let the pipe drain
    task automatic drain_phase();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input bit squared, input logic [1:0] format);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SQUARED_MODE;
        cfg_wdata <= {1'($urandom_range(1)), squared};  // upper bit is don't-care
        @(posedge aclk);
        cfg_addr  <= CFG_OUT_FORMAT;
        cfg_wdata <= format;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                stall = idle_len(rx_idles);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_SQUARED_MODE;
        cfg_wdata <= 2'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        corner_words.push_back(pack_word(0, 0, 0));
        corner_words.push_back(pack_word(1, 0, 0));
        corner_words.push_back(pack_word(1, 1, 0));          // n = 2, rounds down
        corner_words.push_back(pack_word(-1, -1, -1));       // n = 3, rounds up
        corner_words.push_back(pack_word(4, 4, 4));          // n = 48, rounds up to 7
        corner_words.push_back(pack_word(8, 0, 1));          // n = 65, stays 8
        corner_words.push_back(pack_word(3, 4, 0));
        corner_words.push_back(pack_word(2, -2, 1));
        corner_words.push_back(pack_word(255, 0, 0));        // root 255, norm below 16 bits
        corner_words.push_back(pack_word(0, -256, 0));       // root 256, norm 65536
        corner_words.push_back(pack_word(181, 180, 0));
        corner_words.push_back(pack_word(-32768, 0, 0));
        corner_words.push_back(pack_word(32767, 32767, 32767));
        corner_words.push_back(pack_word(-32768, -32768, -32768));
        corner_words.push_back(pack_word(0, -32768, 32767));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: rounded root, 8-bit saturation
        foreach (corner_words[i])
            send_word(corner_words[i]);
        drain_phase();

        for (int p = 0; p < PHASES; p++) begin
            write_config(PHASE_SQUARED[p], PHASE_FORMAT[p]);
            if (p == HOLD_PHASE) begin
                // back-to-back words against a stalled sink fill the pipe
                tx_idles = 1'b0;
                rx_idles = 1'b0;
                hold_req = 1'b1;
            end else begin
                tx_idles = ($urandom_range(3) != 0);
                rx_idles = ($urandom_range(3) != 0);
            end
            repeat (WORDS_PER_PHASE) send_word(rand_word());
            drain_phase();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vte_pkg.sv
rtl/vte_square.sv
rtl/vte_sqrt.sv
rtl/vte_out.sv
rtl/vector_to_euclidean_distance.sv
tb/sv/vte_distance_monitor.sv
tb/sv/vector_to_euclidean_distance_tb.sv
